FILE: hw/rtl/oab_pkg.sv
// oab_pkg: shared types and constants for the overlay alpha blend block.
// Depends on nothing; used by the interfaces and every module in hw/rtl.
package oab_pkg;

    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 13;
    localparam int CoordW    = 12;
    localparam int ChanW     = 8;
    localparam int NumChan   = 3;
    localparam int ProdW     = 2 * ChanW;
    localparam int WinW      = CfgDataW + 2;

    localparam logic [ChanW-1:0] ChanMax = 8'd255;

    localparam logic [CfgIdxW-1:0] CFG_OFFSET_COL     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_OFFSET_ROW     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_OVERLAY_WIDTH  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_OVERLAY_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [CfgDataW-1:0] offset_col;
        logic signed [CfgDataW-1:0] offset_row;
        logic        [CfgDataW-1:0] overlay_width;
        logic        [CfgDataW-1:0] overlay_height;
    } oab_cfg_t;

    typedef struct packed {
        logic [CoordW-1:0]             pixel_col;
        logic [CoordW-1:0]             pixel_row;
        logic [NumChan-1:0][ChanW-1:0] back;
        logic [NumChan-1:0][ChanW-1:0] over;
        logic [ChanW-1:0]              alpha;
    } oab_pix_t;

    typedef struct packed {
        logic [NumChan-1:0][ChanW-1:0] back;
        logic [NumChan-1:0][ChanW-1:0] over;
        logic [ChanW-1:0]              alpha;
        logic                          hit;
    } oab_win_t;

    typedef struct packed {
        logic [NumChan-1:0][ChanW-1:0] chan;
        logic                          in_window;
    } oab_res_t;

endpackage

FILE: hw/rtl/oab_pix_if.sv
// oab_pix_if / oab_res_if: valid/ready channels for pixel transactions and results.
// Depends on oab_pkg for field widths.
interface oab_pix_if;
    logic                           valid;
    logic                           ready;
    logic [oab_pkg::CoordW-1:0]     pixel_col;
    logic [oab_pkg::CoordW-1:0]     pixel_row;
    logic [oab_pkg::ChanW-1:0]      back_ch0;
    logic [oab_pkg::ChanW-1:0]      back_ch1;
    logic [oab_pkg::ChanW-1:0]      back_ch2;
    logic [oab_pkg::ChanW-1:0]      over_ch0;
    logic [oab_pkg::ChanW-1:0]      over_ch1;
    logic [oab_pkg::ChanW-1:0]      over_ch2;
    logic [oab_pkg::ChanW-1:0]      over_alpha;

    modport source (
        output valid, pixel_col, pixel_row, back_ch0, back_ch1, back_ch2,
               over_ch0, over_ch1, over_ch2, over_alpha,
        input  ready
    );
    modport sink (
        input  valid, pixel_col, pixel_row, back_ch0, back_ch1, back_ch2,
               over_ch0, over_ch1, over_ch2, over_alpha,
        output ready
    );
endinterface

interface oab_res_if;
    logic                           valid;
    logic                           ready;
    logic [oab_pkg::ChanW-1:0]      out_ch0;
    logic [oab_pkg::ChanW-1:0]      out_ch1;
    logic [oab_pkg::ChanW-1:0]      out_ch2;
    logic                           in_window;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, in_window,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, in_window,
        output ready
    );
endinterface

FILE: hw/rtl/oab_cfg_regs.sv
// oab_cfg_regs: placement registers written through the plain write port.
// Depends on oab_pkg; dimensions saturate at MAX_DIM.
module oab_cfg_regs #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [oab_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [oab_pkg::CfgDataW-1:0]  cfg_wdata,
    output oab_pkg::oab_cfg_t             cfg
);

    oab_pkg::oab_cfg_t          cfg_reg;
    oab_pkg::oab_cfg_t          cfg_next;
    logic [oab_pkg::CfgDataW-1:0] dim_clamped;

    always_comb
    begin
        if ({19'b0, cfg_wdata} > 32'(MAX_DIM))
        begin
            dim_clamped = oab_pkg::CfgDataW'(MAX_DIM);
        end
        else
        begin
            dim_clamped = cfg_wdata;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                oab_pkg::CFG_OFFSET_COL:     cfg_next.offset_col     = $signed(cfg_wdata);
                oab_pkg::CFG_OFFSET_ROW:     cfg_next.offset_row     = $signed(cfg_wdata);
                oab_pkg::CFG_OVERLAY_WIDTH:  cfg_next.overlay_width  = dim_clamped;
                oab_pkg::CFG_OVERLAY_HEIGHT: cfg_next.overlay_height = dim_clamped;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/oab_window_stage.sv
// oab_window_stage: first pipeline stage, window test and payload capture.
// Depends on oab_pkg.
module oab_window_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oab_pkg::oab_cfg_t    cfg,
    input  oab_pkg::oab_pix_t    pix,
    input  logic                 up_valid,
    output logic                 up_ready,
    output oab_pkg::oab_win_t    win,
    output logic                 dn_valid,
    input  logic                 dn_ready
);

    logic signed [oab_pkg::WinW-1:0] col_s;
    logic signed [oab_pkg::WinW-1:0] row_s;
    logic signed [oab_pkg::WinW-1:0] col_lo;
    logic signed [oab_pkg::WinW-1:0] row_lo;
    logic signed [oab_pkg::WinW-1:0] col_hi;
    logic signed [oab_pkg::WinW-1:0] row_hi;
    logic                            hit;
    logic                            valid_reg;
    logic                            valid_next;
    oab_pkg::oab_win_t               win_reg;
    oab_pkg::oab_win_t               win_next;

    always_comb
    begin
        col_s  = $signed({3'b000, pix.pixel_col});
        row_s  = $signed({3'b000, pix.pixel_row});
        col_lo = {{2{cfg.offset_col[oab_pkg::CfgDataW-1]}}, cfg.offset_col};
        row_lo = {{2{cfg.offset_row[oab_pkg::CfgDataW-1]}}, cfg.offset_row};
        col_hi = col_lo + $signed({2'b00, cfg.overlay_width});
        row_hi = row_lo + $signed({2'b00, cfg.overlay_height});
        hit    = (col_s >= col_lo) && (col_s < col_hi)
              && (row_s >= row_lo) && (row_s < row_hi);
    end

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        win_next.back  = pix.back;
        win_next.over  = pix.over;
        win_next.alpha = pix.alpha;
        win_next.hit   = hit;
        valid_next     = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            win_reg <= win_next;
        end
    end

    assign win      = win_reg;
    assign dn_valid = valid_reg;

endmodule

FILE: hw/rtl/oab_mix_pipe.sv
// oab_mix_pipe: multiply stage and sum/divide-by-255 stage feeding the output register.
// Depends on oab_pkg.
module oab_mix_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  oab_pkg::oab_win_t    win,
    input  logic                 up_valid,
    output logic                 up_ready,
    output oab_pkg::oab_res_t    res,
    output logic                 dn_valid,
    input  logic                 dn_ready
);

    localparam int PW = oab_pkg::ProdW;
    localparam int CW = oab_pkg::ChanW;
    localparam int NC = oab_pkg::NumChan;

    // floor(x / 255) for x <= 255*255
    function automatic logic [CW-1:0] div255(input logic [PW-1:0] x);
        logic [PW:0] t;
        t = {1'b0, x} + {{(CW+1){1'b0}}, x[PW-1:CW]} + {{PW{1'b0}}, 1'b1};
        return t[PW-1:CW];
    endfunction

    logic                          m_valid_reg;
    logic                          m_ready;
    logic [NC-1:0][PW-1:0]         pb_reg;
    logic [NC-1:0][PW-1:0]         po_reg;
    logic [NC-1:0][CW-1:0]         mb_reg;
    logic                          m_inside_reg;
    logic [CW-1:0]                 inv_alpha;

    logic                          o_valid_reg;
    logic                          o_ready;
    oab_pkg::oab_res_t             res_reg;
    oab_pkg::oab_res_t             res_next;

    assign o_ready  = !o_valid_reg || dn_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign up_ready = m_ready;
    assign inv_alpha = oab_pkg::ChanMax - win.alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= up_valid;
            end
            if (o_ready)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready && up_valid)
        begin
            for (int k = 0; k < NC; k++)
            begin
                pb_reg[k] <= {{CW{1'b0}}, win.back[k]} * {{CW{1'b0}}, inv_alpha};
                po_reg[k] <= {{CW{1'b0}}, win.over[k]} * {{CW{1'b0}}, win.alpha};
            end
            mb_reg       <= win.back;
            m_inside_reg <= win.hit;
        end
    end

    always_comb
    begin
        res_next.in_window = m_inside_reg;
        for (int k = 0; k < NC; k++)
        begin
            if (m_inside_reg)
            begin
                res_next.chan[k] = div255(pb_reg[k] + po_reg[k]);
            end
            else
            begin
                res_next.chan[k] = mb_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && m_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res      = res_reg;
    assign dn_valid = o_valid_reg;

endmodule

FILE: hw/rtl/overlay_alpha_blend.sv
// overlay_alpha_blend: composites an overlay window onto a background pixel stream.
// Stages, each registered: window test, multipliers, sum/divide into the output register.
// Throughput: one transaction per cycle while result.ready does not stall the pipe.
// Reset (rst_n, async low) clears pipeline valid bits and all placement registers.
// Depends on oab_pkg, oab_pix_if/oab_res_if, oab_cfg_regs, oab_window_stage, oab_mix_pipe.
module overlay_alpha_blend #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [oab_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [oab_pkg::CfgDataW-1:0]  cfg_wdata,
    oab_pix_if.sink                       pixel,
    oab_res_if.source                     result
);

    oab_pkg::oab_cfg_t  cfg;
    oab_pkg::oab_pix_t  pix;
    oab_pkg::oab_win_t  win;
    logic               win_valid;
    oab_pkg::oab_res_t  res;
    logic               mix_ready;

    oab_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    always_comb
    begin
        pix.pixel_col = pixel.pixel_col;
        pix.pixel_row = pixel.pixel_row;
        pix.back[0]   = pixel.back_ch0;
        pix.back[1]   = pixel.back_ch1;
        pix.back[2]   = pixel.back_ch2;
        pix.over[0]   = pixel.over_ch0;
        pix.over[1]   = pixel.over_ch1;
        pix.over[2]   = pixel.over_ch2;
        pix.alpha     = pixel.over_alpha;
    end

    oab_window_stage u_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pix      (pix),
        .up_valid (pixel.valid),
        .up_ready (pixel.ready),
        .win      (win),
        .dn_valid (win_valid),
        .dn_ready (mix_ready)
    );

    oab_mix_pipe u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win),
        .up_valid (win_valid),
        .up_ready (mix_ready),
        .res      (res),
        .dn_valid (result.valid),
        .dn_ready (result.ready)
    );

    assign result.out_ch0   = res.chan[0];
    assign result.out_ch1   = res.chan[1];
    assign result.out_ch2   = res.chan[2];
    assign result.in_window = res.in_window;

endmodule
